### rtl/indexed_min_heap_core_macros.svh
// ----------------------------------------------------------------------------
// indexed_min_heap_core_macros
// Assertion helpers for the indexed min-heap core.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_CORE_MACROS_SVH
`define INDEXED_MIN_HEAP_CORE_MACROS_SVH

// Check a property every clock edge outside reset
`define IMH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check an implication every clock edge, reset included
`define IMH_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### rtl/imh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_pkg
// Shared constants and types for the indexed min-heap core.
// ----------------------------------------------------------------------------
package imh_pkg;

   localparam int unsigned CAPACITY_DEF    = 1024;
   localparam int unsigned VERTEX_BITS_DEF = 20;
   localparam int unsigned COST_W          = 32;
   localparam int unsigned VERT_W          = 20;
   localparam int unsigned POS_W           = 10;
   localparam int unsigned COUNT_W         = 11;

   localparam logic [1:0] KIND_INSERT  = 2'd0;
   localparam logic [1:0] KIND_REPLACE = 2'd1;
   localparam logic [1:0] KIND_DELETE  = 2'd2;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_NOT_FND  = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_BAD_POS  = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,     // issue read of slot for key search
      S_SRCH_CHK,   // compare read data with key
      S_LAST_RD,    // read last entry for delete
      S_LAST_WAIT,
      S_UP_RD,      // read parent
      S_UP_CMP,
      S_DN_RD1,     // read left child
      S_DN_RD2,     // latch left child, read right child
      S_DN_SEL,     // pick the smaller child
      S_DN_CMP,     // chosen child against the moving entry
      S_TOP_RD,
      S_TOP_WAIT,
      S_RESP
   } state_type;

endpackage

### rtl/imh_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_cmp
// Shared entry comparator: cost, then vert_a, then vert_b.
// ----------------------------------------------------------------------------
module imh_cmp #(
   parameter int unsigned VB = imh_pkg::VERTEX_BITS_DEF
) (
   input  logic [imh_pkg::COST_W-1:0] a_cost,
   input  logic [VB-1:0]              a_va,
   input  logic [VB-1:0]              a_vb,
   input  logic [imh_pkg::COST_W-1:0] b_cost,
   input  logic [VB-1:0]              b_va,
   input  logic [VB-1:0]              b_vb,
   output logic                       a_lt_b
);
   import imh_pkg::*;

   always_comb begin
      if (a_cost != b_cost) begin
         a_lt_b = a_cost < b_cost;
      end else if (a_va != b_va) begin
         a_lt_b = a_va < b_va;
      end else begin
         a_lt_b = a_vb < b_vb;
      end
   end

endmodule

### rtl/indexed_min_heap_core.sv
`timescale 1ns / 1ps
// Response time grows with the levels an insert climbs or a replace sifts down;
//   a delete also scans slots for its key first.
// Throughput: one beat at a time; busy is high from the accept edge through the rsp
//   strobe, so a new beat is taken only after the last one has responded.
//   The receiver cannot stall.
// Reset: synchronous; clears the entry count and the sequencer, slots are left as is.
// ----------------------------------------------------------------------------
// indexed_min_heap_core
// Indexed binary min-heap with insert, replace and delete-by-key.
// ----------------------------------------------------------------------------
`include "indexed_min_heap_core_macros.svh"

module indexed_min_heap_core #(
   parameter int unsigned CAPACITY    = imh_pkg::CAPACITY_DEF,
   parameter int unsigned VERTEX_BITS = imh_pkg::VERTEX_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_kind,
   input  logic [imh_pkg::POS_W-1:0]   req_position,
   input  logic [imh_pkg::COST_W-1:0]  req_cost,
   input  logic [imh_pkg::VERT_W-1:0]  req_vert_a,
   input  logic [imh_pkg::VERT_W-1:0]  req_vert_b,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [imh_pkg::COST_W-1:0]  rsp_top_cost,
   output logic [imh_pkg::VERT_W-1:0]  rsp_top_vert_a,
   output logic [imh_pkg::VERT_W-1:0]  rsp_top_vert_b,
   output logic [imh_pkg::COUNT_W-1:0] rsp_entry_count,
   output logic                        rsp_is_empty
);
   import imh_pkg::*;

   localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW  = $clog2(CAPACITY + 1);
   localparam int unsigned VB  = VERTEX_BITS;
   localparam int unsigned EW  = COST_W + 2 * VB;

   // Slot memory: one port, registered read. An entry is {cost, vert_a, vert_b},
   // so a plain compare of the packed word follows the heap order field by field.
   logic [EW-1:0] mem [CAPACITY];
   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [EW-1:0] mem_wdata;
   logic [EW-1:0] mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_addr];
   end

   state_type     state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] idx_ff, idx_in;       // hole the moving entry sits in
   logic [CW-1:0] scan_ff, scan_in;     // key search pointer
   logic [EW-1:0] ent_ff, ent_in;       // moving entry
   logic [EW-1:0] oth_ff, oth_in;       // chosen child
   logic [CW-1:0] oidx_ff, oidx_in;     // slot of parent or chosen child
   logic [1:0]    stat_ff, stat_in;
   logic [VB-1:0] kva_ff, kva_in, kvb_ff, kvb_in;
   logic          dn_ff, dn_in;         // sift down still wanted (replace or delete refill, no climb)
   logic [EW-1:0] top_ff, top_in;

   // Shared comparator: entry vs parent, right vs left child, child vs entry
   logic [EW-1:0] ca, cb;
   logic          a_lt_b;

   imh_cmp #(.VB(VB)) u_cmp (
      .a_cost(ca[EW-1 -: COST_W]), .a_va(ca[2*VB-1 -: VB]), .a_vb(ca[VB-1:0]),
      .b_cost(cb[EW-1 -: COST_W]), .b_va(cb[2*VB-1 -: VB]), .b_vb(cb[VB-1:0]),
      .a_lt_b(a_lt_b)
   );

   always_comb begin
      ca = ent_ff;
      cb = mem_rdata_ff;
      case (state_ff)
         S_DN_SEL: begin
            ca = mem_rdata_ff;
            cb = oth_ff;
         end
         S_DN_CMP: begin
            ca = oth_ff;
            cb = ent_ff;
         end
         default: begin
            ca = ent_ff;
            cb = mem_rdata_ff;
         end
      endcase
   end

   // Slot arithmetic and simple flags
   logic [CW:0]   lchild, rchild;
   logic [CW-1:0] parent;
   logic [CW-1:0] last_idx;
   logic          l_none;               // no left child: sift down ends here
   logic          r_some;               // right child is occupied
   logic          key_hit;
   logic          pos_ok;

   always_comb begin
      lchild   = {idx_ff, 1'b1};
      rchild   = {idx_ff, 1'b0} + (CW+1)'(2);
      parent   = (idx_ff - CW'(1)) >> 1;
      last_idx = fill_ff - CW'(1);
      l_none   = lchild >= {1'b0, fill_ff};
      r_some   = rchild < {1'b0, fill_ff};
      key_hit  = mem_rdata_ff[2*VB-1:0] == {kva_ff, kvb_ff};
      pos_ok   = 32'(req_position) < 32'(fill_ff);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_kind)
                  KIND_INSERT: begin
                     state_in = (fill_ff >= CW'(CAPACITY)) ? S_TOP_RD : S_UP_RD;
                  end
                  KIND_REPLACE: state_in = pos_ok ? S_UP_RD : S_TOP_RD;
                  KIND_DELETE:  state_in = (fill_ff == '0) ? S_TOP_RD : S_SEARCH;
                  default:      state_in = S_TOP_RD;
               endcase
            end
         end
         S_SEARCH: state_in = S_SRCH_CHK;
         S_SRCH_CHK: begin
            if (key_hit) begin
               // hit on the tail slot: the entry is simply dropped
               state_in = (scan_ff == last_idx) ? S_TOP_RD : S_LAST_RD;
            end else if (scan_ff == last_idx) begin
               state_in = S_TOP_RD;
            end else begin
               state_in = S_SEARCH;
            end
         end
         S_LAST_RD:   state_in = S_LAST_WAIT;
         S_LAST_WAIT: state_in = S_UP_RD;
         S_UP_RD: begin
            if (idx_ff == '0) begin
               state_in = dn_ff ? S_DN_RD1 : S_TOP_RD;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (a_lt_b) begin
               state_in = S_UP_RD;
            end else begin
               state_in = dn_ff ? S_DN_RD1 : S_TOP_RD;
            end
         end
         S_DN_RD1:   state_in = l_none ? S_TOP_RD : S_DN_RD2;
         S_DN_RD2:   state_in = S_DN_SEL;
         S_DN_SEL:   state_in = S_DN_CMP;
         S_DN_CMP:   state_in = a_lt_b ? S_DN_RD1 : S_TOP_RD;
         S_TOP_RD:   state_in = S_TOP_WAIT;
         S_TOP_WAIT: state_in = S_RESP;
         S_RESP:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // Datapath registers
   always_comb begin
      fill_in = fill_ff;
      idx_in  = idx_ff;
      scan_in = scan_ff;
      ent_in  = ent_ff;
      oth_in  = oth_ff;
      oidx_in = oidx_ff;
      stat_in = stat_ff;
      kva_in  = kva_ff;
      kvb_in  = kvb_ff;
      dn_in   = dn_ff;
      top_in  = top_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               kva_in  = VB'(req_vert_a);
               kvb_in  = VB'(req_vert_b);
               ent_in  = {req_cost, VB'(req_vert_a), VB'(req_vert_b)};
               stat_in = ST_DONE;
               dn_in   = 1'b0;
               scan_in = '0;
               case (req_kind)
                  KIND_INSERT: begin
                     if (fill_ff >= CW'(CAPACITY)) begin
                        stat_in = ST_FULL;
                     end else begin
                        idx_in  = fill_ff;
                        fill_in = fill_ff + CW'(1);
                     end
                  end
                  KIND_REPLACE: begin
                     if (!pos_ok) begin
                        stat_in = ST_BAD_POS;
                     end else begin
                        idx_in = CW'(req_position);
                        dn_in  = 1'b1;
                     end
                  end
                  KIND_DELETE: begin
                     if (fill_ff == '0) begin
                        stat_in = ST_NOT_FND;
                     end
                  end
                  default: stat_in = ST_DONE;
               endcase
            end
         end
         S_SRCH_CHK: begin
            if (key_hit) begin
               idx_in  = scan_ff;
               fill_in = last_idx;
            end else if (scan_ff == last_idx) begin
               stat_in = ST_NOT_FND;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         S_LAST_WAIT: begin
            // tail entry refills the freed slot like a replace
            ent_in = mem_rdata_ff;
            dn_in  = 1'b1;
         end
         S_UP_RD: begin
            if (idx_ff != '0) begin
               oidx_in = parent;
            end
         end
         S_UP_CMP: begin
            // once the entry climbs, the slot below it stays ordered: no sift down
            if (a_lt_b) begin
               idx_in = oidx_ff;
               dn_in  = 1'b0;
            end
         end
         S_DN_RD2: begin
            oth_in  = mem_rdata_ff;
            oidx_in = lchild[CW-1:0];
         end
         S_DN_SEL: begin
            // right child wins only when strictly smaller
            if (r_some && a_lt_b) begin
               oth_in  = mem_rdata_ff;
               oidx_in = rchild[CW-1:0];
            end
         end
         S_DN_CMP: begin
            if (a_lt_b) begin
               idx_in = oidx_ff;
            end
         end
         S_TOP_WAIT: top_in = mem_rdata_ff;
         default: top_in = top_ff;
      endcase
   end

   // Memory port: the entry rides in a hole and is written into it wherever it settles
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = '0;
      mem_wdata = ent_ff;
      case (state_ff)
         S_SEARCH:  mem_addr = scan_ff[AW-1:0];
         S_LAST_RD: mem_addr = fill_ff[AW-1:0];
         S_UP_RD: begin
            if (idx_ff == '0) begin
               mem_we   = 1'b1;
               mem_addr = '0;
            end else begin
               mem_addr = parent[AW-1:0];
            end
         end
         S_UP_CMP: begin
            // parent moves down into the hole, or the entry settles there
            mem_we   = 1'b1;
            mem_addr = idx_ff[AW-1:0];
            if (a_lt_b) begin
               mem_wdata = mem_rdata_ff;
            end
         end
         S_DN_RD1: begin
            if (l_none) begin
               mem_we   = 1'b1;
               mem_addr = idx_ff[AW-1:0];
            end else begin
               mem_addr = lchild[AW-1:0];
            end
         end
         S_DN_RD2: mem_addr = r_some ? rchild[AW-1:0] : '0;
         S_DN_CMP: begin
            // child moves up into the hole, or the entry settles there
            mem_we   = 1'b1;
            mem_addr = idx_ff[AW-1:0];
            if (a_lt_b) begin
               mem_wdata = oth_ff;
            end
         end
         S_TOP_RD: mem_addr = '0;
         default:  mem_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
      idx_ff  <= idx_in;
      scan_ff <= scan_in;
      ent_ff  <= ent_in;
      oth_ff  <= oth_in;
      oidx_ff <= oidx_in;
      stat_ff <= stat_in;
      kva_ff  <= kva_in;
      kvb_ff  <= kvb_in;
      dn_ff   <= dn_in;
      top_ff  <= top_in;
   end

   // Outputs; an empty heap reports a zero top entry
   logic nonempty;
   always_comb begin
      nonempty        = fill_ff != '0;
      busy            = state_ff != S_IDLE;
      rsp_valid       = state_ff == S_RESP;
      rsp_status      = stat_ff;
      rsp_top_cost    = nonempty ? top_ff[EW-1 -: COST_W] : '0;
      rsp_top_vert_a  = nonempty ? VERT_W'(top_ff[2*VB-1 -: VB]) : '0;
      rsp_top_vert_b  = nonempty ? VERT_W'(top_ff[VB-1:0]) : '0;
      rsp_entry_count = COUNT_W'(fill_ff);
      rsp_is_empty    = !nonempty;
   end

   `IMH_ASSERT(a_fill_cap, fill_ff <= CW'(CAPACITY), "fill count above capacity")
   `IMH_ASSERT(a_resp_once, rsp_valid |=> !rsp_valid, "response strobe longer than one cycle")
   `IMH_ASSERT(a_no_rsp_idle, rsp_valid |-> busy, "response outside a busy operation")
   `IMH_ASSERT_ALWAYS(a_reset_idle, reset |=> !busy, "busy right after reset")

endmodule
